FILE: rtl/core/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg
// shared types and constants of the priority task scheduler
// ----------------------------------------------------------------------------
package pts_pkg;

    localparam int TASK_COUNT = 16;
    localparam int DELAY_BITS = 16;

    // fixed field widths
    localparam int OP_W    = 3;
    localparam int IDX_W   = 5;
    localparam int TICKS_W = 16;
    localparam int MAP_W   = TASK_COUNT + 1;
    // index of a task below the idle task
    localparam int TW      = $clog2(TASK_COUNT);

    localparam logic [OP_W-1:0] OP_CREATE  = 3'd0;
    localparam logic [OP_W-1:0] OP_SUSPEND = 3'd1;
    localparam logic [OP_W-1:0] OP_RESUME  = 3'd2;
    localparam logic [OP_W-1:0] OP_DELAY   = 3'd3;
    localparam logic [OP_W-1:0] OP_TICK    = 3'd4;
    localparam logic [OP_W-1:0] OP_START   = 3'd5;

    localparam logic [IDX_W-1:0] IDLE_TASK = IDX_W'(TASK_COUNT);

    typedef enum logic [1:0] {
        MODE_READY = 2'd0,
        MODE_DELAY = 2'd1,
        MODE_SUSP  = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [IDX_W-1:0]   priority_req;
        logic [TICKS_W-1:0] delay_ticks;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0] current_task;
        logic             switched;
        logic [MAP_W-1:0] ready_map;
    } t_out_item;

    // commands into the task table
    typedef struct packed {
        logic                  set_en;
        logic [TW-1:0]         set_idx;
        t_mode                 set_mode;
        logic                  load_en;
        logic [DELAY_BITS-1:0] load_val;
        logic                  step_en;
        logic [TW-1:0]         step_idx;
    } t_tbl_cmd;

    typedef struct packed {
        logic expired;
    } t_tbl_rsp;

endpackage

FILE: rtl/core/pts_task_table.sv
// ----------------------------------------------------------------------------
// pts_task_table
// per-task mode and delay counter with one shared decrement unit
// ----------------------------------------------------------------------------
module pts_task_table (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pts_pkg::t_tbl_cmd i_cmd,
    output pts_pkg::t_tbl_rsp o_rsp
);
    import pts_pkg::*;

    t_mode                 r_mode  [TASK_COUNT];
    logic [DELAY_BITS-1:0] r_delay [TASK_COUNT];

    t_mode                 step_mode;
    logic [DELAY_BITS-1:0] step_dec;
    logic                  step_hit;

    // shared decrement and zero compare
    always_comb begin
        step_mode     = r_mode[i_cmd.step_idx];
        step_dec      = r_delay[i_cmd.step_idx] - DELAY_BITS'(1);
        step_hit      = i_cmd.step_en && (step_mode == MODE_DELAY);
        o_rsp.expired = step_hit && (step_dec == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TASK_COUNT; i++) begin
                r_mode[i] <= MODE_READY;
            end
        end else if (i_cmd.set_en) begin
            r_mode[i_cmd.set_idx] <= i_cmd.set_mode;
        end else if (o_rsp.expired) begin
            r_mode[i_cmd.step_idx] <= MODE_READY;
        end
    end

    // counter is only read while its task is delayed, so it needs no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_en) begin
            r_delay[i_cmd.set_idx] <= i_cmd.load_val;
        end else if (step_hit) begin
            r_delay[i_cmd.step_idx] <= step_dec;
        end
    end

endmodule

FILE: rtl/core/priority_task_scheduler_top.sv
// ----------------------------------------------------------------------------
// priority_task_scheduler_top
// fixed-priority task scheduler with ready bitmap and delay counters
// ----------------------------------------------------------------------------
// One input beat is one scheduler event (create, suspend, resume, delay,
// tick, start) and yields exactly one output beat with the running task,
// a switched flag and the ready bitmap. Task 0 has the highest priority,
// the idle task sits at index TASK_COUNT. Events that do not reschedule go
// straight to the finish state. Events that reschedule first walk all
// TASK_COUNT tasks through the task table, one task per cycle, before they
// reach the finish state; the walk drives the single decrement unit for
// ticks and finds the highest-priority ready task on the way. The input is
// not ready during that walk. A finished result sits in an output register,
// so the next event is accepted while the result still waits. The enable
// register is written over its own channel, which is always ready.
// ----------------------------------------------------------------------------
module priority_task_scheduler_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // event input
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  pts_pkg::t_in_item  i_in_item,
    // result output
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output pts_pkg::t_out_item o_out_item,
    // enable register write
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_data
);
    import pts_pkg::*;

    t_state           r_state, n_state;
    logic [MAP_W-1:0] r_ready, n_ready;
    logic [IDX_W-1:0] r_running, n_running;
    logic             r_enable;
    logic             r_sw, n_sw;
    logic             r_tick, n_tick;
    logic [TW-1:0]    r_idx, n_idx;
    logic             r_found, n_found;
    logic [TW-1:0]    r_first, n_first;
    logic             r_out_valid;
    t_out_item        r_out_item;

    t_tbl_cmd tbl_cmd;
    t_tbl_rsp tbl_rsp;

    logic in_fire;
    logic out_free;
    logic walk_last;
    logic need_walk;
    logic prio_ok;
    logic prio_tbl;
    logic run_tbl;
    logic bit_now;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign out_free    = !r_out_valid || i_out_ready;
    assign walk_last   = (r_idx == TW'(TASK_COUNT - 1));

    // event decode
    always_comb begin
        prio_ok  = (i_in_item.priority_req <= IDLE_TASK);
        prio_tbl = (i_in_item.priority_req < IDLE_TASK);
        run_tbl  = (r_running < IDLE_TASK);
        unique case (i_in_item.operation) inside
            OP_SUSPEND, OP_RESUME: begin
                need_walk = prio_ok && (r_running == i_in_item.priority_req);
            end
            OP_DELAY: begin
                need_walk = (i_in_item.delay_ticks[DELAY_BITS-1:0] != '0);
            end
            OP_TICK:  need_walk = r_enable;
            OP_START: need_walk = 1'b1;
            default:  need_walk = 1'b0;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_state = need_walk ? ST_WALK : ST_FIN;
                end
            end
            ST_WALK: begin
                if (walk_last) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and table commands
    always_comb begin
        n_ready   = r_ready;
        n_running = r_running;
        n_sw      = r_sw;
        n_tick    = r_tick;
        n_idx     = r_idx;
        n_found   = r_found;
        n_first   = r_first;
        bit_now   = 1'b0;

        tbl_cmd          = '0;
        tbl_cmd.set_mode = MODE_READY;
        tbl_cmd.load_val = i_in_item.delay_ticks[DELAY_BITS-1:0];
        tbl_cmd.step_idx = r_idx;

        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_sw    = need_walk;
                    n_tick  = (i_in_item.operation == OP_TICK);
                    n_idx   = '0;
                    n_found = 1'b0;
                    n_first = '0;
                    unique case (i_in_item.operation) inside
                        OP_CREATE, OP_RESUME: begin
                            if (prio_ok) begin
                                n_ready[i_in_item.priority_req] = 1'b1;
                                tbl_cmd.set_en   = prio_tbl;
                                tbl_cmd.set_idx  = i_in_item.priority_req[TW-1:0];
                                tbl_cmd.set_mode = MODE_READY;
                            end
                        end
                        OP_SUSPEND: begin
                            if (prio_ok) begin
                                n_ready[i_in_item.priority_req] = 1'b0;
                                tbl_cmd.set_en   = prio_tbl;
                                tbl_cmd.set_idx  = i_in_item.priority_req[TW-1:0];
                                tbl_cmd.set_mode = MODE_SUSP;
                            end
                        end
                        OP_DELAY: begin
                            if (need_walk) begin
                                n_ready[r_running] = 1'b0;
                                tbl_cmd.set_en   = run_tbl;
                                tbl_cmd.load_en  = run_tbl;
                                tbl_cmd.set_idx  = r_running[TW-1:0];
                                tbl_cmd.set_mode = MODE_DELAY;
                            end
                        end
                        OP_START: begin
                            n_ready[TASK_COUNT] = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            ST_WALK: begin
                tbl_cmd.step_en = r_tick;
                bit_now = r_ready[IDX_W'(r_idx)] || tbl_rsp.expired;
                if (tbl_rsp.expired) begin
                    n_ready[IDX_W'(r_idx)] = 1'b1;
                end
                if (!r_found && bit_now) begin
                    n_found = 1'b1;
                    n_first = r_idx;
                end
                n_idx = r_idx + TW'(1);
                if (walk_last) begin
                    n_running = n_found ? IDX_W'(n_first) : IDLE_TASK;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ready     <= '0;
            r_running   <= IDLE_TASK;
            r_enable    <= 1'b1;
            r_sw        <= 1'b0;
            r_tick      <= 1'b0;
            r_idx       <= '0;
            r_found     <= 1'b0;
            r_first     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ready   <= n_ready;
            r_running <= n_running;
            r_sw      <= n_sw;
            r_tick    <= n_tick;
            r_idx     <= n_idx;
            r_found   <= n_found;
            r_first   <= n_first;
            if (i_cfg_valid) begin
                r_enable <= i_cfg_data;
            end
            // result beat leaves the finish state into the output register
            if (r_state == ST_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_FIN && out_free) begin
            r_out_item.current_task <= r_running;
            r_out_item.switched     <= r_sw;
            r_out_item.ready_map    <= r_ready;
        end
    end

    pts_task_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (tbl_cmd),
        .o_rsp   (tbl_rsp)
    );

endmodule

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the priority task scheduler
// ----------------------------------------------------------------------------
// Every event beat goes through an in-bench scheduler model at the moment it
// is accepted, and the model's answer is queued. Each result beat is then
// checked field by field against the oldest queued answer. The run covers a
// short directed walk through create, suspend, resume, delay, tick and start,
// the tick gate of the enable register, and a long random stretch built
// around the running task. A long output hold lets the block back up
// against its input.
// ----------------------------------------------------------------------------
module tb_top;

    import pts_pkg::*;

    // opcodes that the block has no use for
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    // the limit leaves plenty of room over the slowest legal run
    localparam int CYCLE_LIMIT = 600000;
    // cycles a rescheduling event needs inside the block, plus a little slack
    localparam int EVENT_CYCLES = TASK_COUNT + 4;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_item;
    logic      i_cfg_valid;
    logic      o_cfg_ready;
    logic      i_cfg_data;

    priority_task_scheduler_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // scheduler model state
    // ------------------------------------------------------------------
    logic [MAP_W-1:0]      model_ready;
    t_mode                 model_mode  [0:TASK_COUNT];
    logic [DELAY_BITS-1:0] model_delay [0:TASK_COUNT];
    logic [IDX_W-1:0]      model_running;
    logic                  model_enable;

    // answers waiting for their result beat
    t_out_item expected_results[$];
    t_out_item want_item;

    int  mismatch_count;
    int  cycle_count;
    bit  src_gaps_on;
    bit  sink_gaps_on;
    // long output hold, counted down by the sink process
    int  sink_hold_cycles;
    int  sink_stall_left;

    // ------------------------------------------------------------------
    // clock, timeout
    // ------------------------------------------------------------------
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // model: lowest-index ready task below idle, else idle
    // ------------------------------------------------------------------
    function automatic logic [IDX_W-1:0] highest_ready();
        for (int i = 0; i < TASK_COUNT; i++) begin
            if (model_ready[i]) begin
                return IDX_W'(i);
            end
        end
        return IDLE_TASK;
    endfunction

    // apply one event to the model and return the result it must produce
    function automatic t_out_item schedule_event(input t_in_item ev);
        t_out_item res;
        logic      sw;
        logic      known;
        int        idx;
        int        cur;
        sw    = 1'b0;
        known = (ev.priority_req <= IDLE_TASK);
        idx   = ev.priority_req;
        cur   = model_running;
        case (ev.operation)
            OP_CREATE: begin
                if (known) begin
                    model_ready[idx] = 1'b1;
                    model_mode[idx]  = MODE_READY;
                end
            end
            OP_SUSPEND: begin
                if (known) begin
                    model_delay[idx] = '0;
                    model_mode[idx]  = MODE_SUSP;
                    model_ready[idx] = 1'b0;
                    if (model_running == ev.priority_req) begin
                        model_running = highest_ready();
                        sw = 1'b1;
                    end
                end
            end
            OP_RESUME: begin
                if (known) begin
                    model_ready[idx] = 1'b1;
                    model_delay[idx] = '0;
                    model_mode[idx]  = MODE_READY;
                    if (model_running == ev.priority_req) begin
                        model_running = highest_ready();
                        sw = 1'b1;
                    end
                end
            end
            OP_DELAY: begin
                // the idle task gets parked too
                if (DELAY_BITS'(ev.delay_ticks) != '0) begin
                    model_ready[cur] = 1'b0;
                    model_delay[cur] = DELAY_BITS'(ev.delay_ticks);
                    model_mode[cur]  = MODE_DELAY;
                    model_running    = highest_ready();
                    sw = 1'b1;
                end
            end
            OP_TICK: begin
                if (model_enable) begin
                    // the idle task's counter is never walked
                    for (int i = 0; i < TASK_COUNT; i++) begin
                        if (model_mode[i] == MODE_DELAY) begin
                            model_delay[i] = model_delay[i] - 1'b1;
                            if (model_delay[i] == '0) begin
                                model_mode[i]  = MODE_READY;
                                model_ready[i] = 1'b1;
                            end
                        end
                    end
                    model_running = highest_ready();
                    sw = 1'b1;
                end
            end
            OP_START: begin
                model_ready[TASK_COUNT] = 1'b1;
                model_mode[TASK_COUNT]  = MODE_READY;
                model_running = highest_ready();
                sw = 1'b1;
            end
            default: begin
            end
        endcase
        res.current_task = model_running;
        res.switched     = sw;
        res.ready_map    = model_ready;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result beat with nothing expected");
            end else begin
                want_item = expected_results.pop_front();
                if (o_out_item.current_task !== want_item.current_task)
                    report_mismatch($sformatf("current_task got %0d want %0d",
                        o_out_item.current_task, want_item.current_task));
                if (o_out_item.switched !== want_item.switched)
                    report_mismatch($sformatf("switched got %b want %b",
                        o_out_item.switched, want_item.switched));
                if (o_out_item.ready_map !== want_item.ready_map)
                    report_mismatch($sformatf("ready_map got %h want %h",
                        o_out_item.ready_map, want_item.ready_map));
            end
        end
    end

    // ------------------------------------------------------------------
    // result sink: random stall bursts plus an optional long hold
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (sink_hold_cycles > 0) begin
            i_out_ready <= 1'b0;
            sink_hold_cycles--;
        end else if (sink_stall_left > 0) begin
            i_out_ready <= 1'b0;
            sink_stall_left--;
        end else if (sink_gaps_on && $urandom_range(0, 7) == 0) begin
            // ready drops now, and sink_stall_left keeps it low afterwards
            i_out_ready     <= 1'b0;
            sink_stall_left = $urandom_range(0, 7);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // event source
    // ------------------------------------------------------------------
    function automatic t_in_item make_event(input logic [OP_W-1:0] op,
                                            input logic [IDX_W-1:0] idx,
                                            input logic [TICKS_W-1:0] ticks);
        t_in_item ev;
        ev.operation    = op;
        ev.priority_req = idx;
        ev.delay_ticks  = ticks;
        return ev;
    endfunction

    // valid stays high from beat to beat unless a gap is taken
    task automatic send_event(input t_in_item ev);
        int gap;
        if (src_gaps_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 8);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= ev;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        expected_results.push_back(schedule_event(ev));
    endtask

    task automatic send(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                        input logic [TICKS_W-1:0] ticks);
        send_event(make_event(op, idx, ticks));
    endtask

    // drop valid and wait until every result beat is back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    // enable register write, only with the block idle
    task automatic write_enable(input logic en);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= en;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        model_enable = en;
        i_cfg_valid <= 1'b0;
    endtask

    // random event, mostly aimed at the running task so suspend, resume
    // and short delays actually move the schedule around
    function automatic t_in_item pick_event();
        t_in_item         ev;
        int               r;
        logic [IDX_W-1:0] idx;
        logic [TICKS_W-1:0] ticks;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 85) idx = IDX_W'($urandom_range(0, TASK_COUNT));
        else                            idx = IDX_W'($urandom_range(0, 31));
        r = $urandom_range(0, 99);
        if (r < 70)      ticks = TICKS_W'($urandom_range(1, 6));
        else if (r < 80) ticks = '0;
        else             ticks = TICKS_W'($urandom_range(0, 65535));
        r = $urandom_range(0, 99);
        if (r < 20) begin
            ev = make_event(OP_CREATE, idx, ticks);
        end else if (r < 30) begin
            if ($urandom_range(0, 1) == 0) idx = model_running;
            ev = make_event(OP_SUSPEND, idx, ticks);
        end else if (r < 40) begin
            if ($urandom_range(0, 1) == 0) idx = model_running;
            ev = make_event(OP_RESUME, idx, ticks);
        end else if (r < 58) begin
            ev = make_event(OP_DELAY, idx, ticks);
        end else if (r < 85) begin
            ev = make_event(OP_TICK, idx, ticks);
        end else if (r < 92) begin
            ev = make_event(OP_START, idx, ticks);
        end else begin
            // raw noise, every opcode including the unused ones
            ev = make_event(OP_W'($urandom_range(0, 7)), IDX_W'($urandom_range(0, 31)),
                            TICKS_W'($urandom_range(0, 65535)));
        end
        return ev;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        send(OP_TICK,    5'd0,      16'd0);      // tick with nothing to do
        send(OP_START,   5'd0,      16'd0);
        send(OP_CREATE,  5'd31,     16'd0);      // out of range index
        send(OP_CREATE,  5'd17,     16'd0);      // just past idle
        send(OP_CREATE,  IDLE_TASK, 16'd0);
        send(OP_CREATE,  5'd15,     16'd0);
        send(OP_CREATE,  5'd0,      16'hFFFF);
        send(OP_START,   5'd0,      16'd0);      // picks task 0
        send(OP_SUSPEND, 5'd0,      16'd0);      // current task suspended
        send(OP_RESUME,  5'd0,      16'd0);      // not current, no switch
        send(OP_DELAY,   5'd0,      16'd0);      // zero delay is a no-op
        send(OP_DELAY,   5'd0,      16'd1);      // park task 15
        send(OP_TICK,    5'd0,      16'd0);      // task 15 expires
        send(OP_DELAY,   5'd0,      16'hFFFF);   // longest delay on task 0
        send(OP_SUSPEND, IDLE_TASK, 16'd0);
        send(OP_SUSPEND, 5'd15,     16'd0);      // falls back to idle
        send(OP_DELAY,   5'd0,      16'd2);      // idle task gets parked
        send(OP_TICK,    5'd0,      16'd0);
        send(OP_TICK,    5'd0,      16'd0);      // idle never counts down
        send(OP_RESUME,  IDLE_TASK, 16'd0);      // resume of current idle
        send(OP_SPARE_LO, 5'd31,    16'hFFFF);
        send(OP_SPARE_HI, 5'd31,    16'hFFFF);
        send(OP_RESUME,  5'd31,     16'hFFFF);
        send(OP_SUSPEND, 5'd31,     16'hFFFF);
        send(OP_RESUME,  5'd0,      16'd0);
    endtask

    // ticks must be dead while the enable bit is clear
    task automatic test_tick_gate();
        write_enable(1'b0);
        send(OP_CREATE, 5'd3, 16'd0);
        send(OP_START,  5'd0, 16'd0);
        send(OP_DELAY,  5'd0, 16'd1);
        send(OP_TICK,   5'd0, 16'd0);
        send(OP_TICK,   5'd0, 16'd0);
        write_enable(1'b1);
        send(OP_TICK,   5'd0, 16'd0);
        send(OP_TICK,   5'd0, 16'd0);
    endtask

    task automatic test_random(input int count);
        for (int n = 0; n < count; n++) begin
            send_event(pick_event());
        end
    endtask

    // hold the output long enough that the block stops taking events
    task automatic test_output_hold();
        sink_hold_cycles = 300;
        test_random(20);
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n          <= 1'b0;
        i_in_valid       <= 1'b0;
        i_in_item        <= '0;
        i_out_ready      <= 1'b0;
        i_cfg_valid      <= 1'b0;
        i_cfg_data       <= 1'b0;
        mismatch_count   = 0;
        cycle_count      = 0;
        src_gaps_on      = 1'b1;
        sink_gaps_on     = 1'b1;
        sink_hold_cycles = 0;
        sink_stall_left  = 0;

        // model reset state
        model_ready   = '0;
        model_running = IDLE_TASK;
        model_enable  = 1'b1;
        for (int i = 0; i <= TASK_COUNT; i++) begin
            model_mode[i]  = MODE_READY;
            model_delay[i] = '0;
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_tick_gate();
        test_random(500);
        write_enable(1'b0);
        test_random(150);
        write_enable(1'b1);
        test_random(450);
        test_output_hold();

        // last stretch runs at full rate on both sides
        wait_drained();
        src_gaps_on  = 1'b0;
        sink_gaps_on = 1'b0;
        test_random(550);

        wait_drained();
        repeat (EVENT_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
